FILE: rtl/sorted_key_list_unit_assert.svh
// assertion macros for the sorted key list
`ifndef SORTED_KEY_LIST_UNIT_ASSERT_SVH
`define SORTED_KEY_LIST_UNIT_ASSERT_SVH

// same-cycle implication
`define SKL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key list check failed");

// next-cycle implication
`define SKL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key list check failed");

`endif

FILE: rtl/skl_pkg.sv
`timescale 1ns / 1ps

package skl_pkg;

    localparam int KEY_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int FIELD_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2
    } skl_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } skl_status_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic             do_insert;
        logic             do_delete;
        logic [KEY_W-1:0] key;
    } skl_bcast_t;

endpackage

FILE: rtl/skl_cell.sv
`timescale 1ns / 1ps

module skl_cell
(
    input  logic                          clk,
    input  skl_pkg::skl_bcast_t           bc,
    input  logic                          occ,
    input  logic                          head,
    input  logic [skl_pkg::KEY_W-1:0]     left_key,
    input  logic                          left_ins,
    input  logic [skl_pkg::KEY_W-1:0]     right_key,
    output logic [skl_pkg::KEY_W-1:0]     key_q,
    output logic                          ins,
    output logic                          eq
);

    logic [skl_pkg::KEY_W-1:0] key_reg;
    logic [skl_pkg::KEY_W-1:0] key_next;
    logic                      gt;
    logic                      ge;

    assign gt    = occ && ($signed(key_reg) > $signed(bc.key));
    assign ge    = occ && !($signed(key_reg) < $signed(bc.key));
    assign eq    = occ && (key_reg == bc.key);
    assign ins   = gt || head;
    assign key_q = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (bc.do_insert)
        begin
            if (left_ins)
            begin
                key_next = left_key;
            end
            else if (ins)
            begin
                key_next = bc.key;
            end
        end
        else if (bc.do_delete && ge)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

FILE: rtl/sorted_key_list_unit.sv
`timescale 1ns / 1ps
// channel  | ports                          | transfer
// ---------+--------------------------------+---------------------------
// command  | command, key                   | start high while busy low
// result   | status, position, entry_count  | done high for one cycle
//
// an accepted command executes on the next edge across all cells at once
// its result is registered at that same edge and shown with done for one cycle
// busy is high during the execute cycle, so no new command is taken while one executes
// results cannot be stalled
// reset clears the key count, cell contents stay undefined until written

module sorted_key_list_unit
#(
    parameter int CAPACITY = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [skl_pkg::CMD_W-1:0]     command,
    input  logic signed [skl_pkg::KEY_W-1:0] key,
    output logic                          done,
    output logic [skl_pkg::STAT_W-1:0]    status,
    output logic [skl_pkg::FIELD_W-1:0]   position,
    output logic [skl_pkg::FIELD_W-1:0]   entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic                            pend_reg;
    logic                            pend_next;
    logic [skl_pkg::CMD_W-1:0]       cmd_reg;
    logic [skl_pkg::KEY_W-1:0]       key_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic                            done_reg;
    logic                            done_next;
    logic [skl_pkg::STAT_W-1:0]      status_reg;
    logic [skl_pkg::STAT_W-1:0]      status_next;
    logic [skl_pkg::FIELD_W-1:0]     position_reg;
    logic [skl_pkg::FIELD_W-1:0]     position_next;
    logic [skl_pkg::FIELD_W-1:0]     entry_count_reg;

    skl_pkg::skl_bcast_t             bc;
    logic [skl_pkg::KEY_W-1:0]       cell_key [CAPACITY];
    logic [CAPACITY-1:0]             cell_ins;
    logic [CAPACITY-1:0]             cell_eq;
    logic [CAPACITY-1:0]             first_ins;
    logic [CAPACITY-1:0]             first_eq;
    logic [CAPACITY-1:0]             occ;
    logic [CAPACITY-1:0]             head;
    logic                            full;
    logic                            hit;
    logic                            is_ins;
    logic                            is_del;
    logic                            is_srch;
    logic [IW-1:0]                   ins_pos;
    logic [IW-1:0]                   eq_pos;

    assign full    = (count_reg == CW'(CAPACITY));
    assign hit     = |cell_eq;
    assign is_ins  = pend_reg && (cmd_reg == skl_pkg::CMD_INSERT);
    assign is_del  = pend_reg && (cmd_reg == skl_pkg::CMD_DELETE);
    assign is_srch = pend_reg && (cmd_reg == skl_pkg::CMD_SEARCH);

    assign bc.do_insert = is_ins && !full;
    assign bc.do_delete = is_del && hit;
    assign bc.key       = key_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [skl_pkg::KEY_W-1:0] lk;
            logic [skl_pkg::KEY_W-1:0] rk;
            logic                      li;
            logic                      le;

            assign occ[g]  = (CW'(g) < count_reg);
            assign head[g] = (CW'(g) == count_reg);

            if (g == 0)
            begin : g_first
                assign lk = cell_key[g];
                assign li = 1'b0;
                assign le = 1'b0;
            end
            else
            begin : g_rest
                assign lk = cell_key[g-1];
                assign li = cell_ins[g-1];
                assign le = cell_eq[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign rk = cell_key[g];
            end
            else
            begin : g_inner
                assign rk = cell_key[g+1];
            end

            assign first_ins[g] = cell_ins[g] && !li;
            assign first_eq[g]  = cell_eq[g] && !le;

            skl_cell u_cell
            (
                .clk       (clk),
                .bc        (bc),
                .occ       (occ[g]),
                .head      (head[g]),
                .left_key  (lk),
                .left_ins  (li),
                .right_key (rk),
                .key_q     (cell_key[g]),
                .ins       (cell_ins[g]),
                .eq        (cell_eq[g])
            );
        end
    endgenerate

    always_comb
    begin
        ins_pos = '0;
        eq_pos  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_ins[i])
            begin
                ins_pos = ins_pos | IW'(i);
            end
            if (first_eq[i])
            begin
                eq_pos = eq_pos | IW'(i);
            end
        end
    end

    always_comb
    begin
        pend_next     = pend_reg;
        count_next    = count_reg;
        done_next     = pend_reg;
        status_next   = skl_pkg::ST_MISSING;
        position_next = '0;
        if (start && !pend_reg)
        begin
            pend_next = 1'b1;
        end
        else if (pend_reg)
        begin
            pend_next = 1'b0;
        end
        if (is_ins)
        begin
            if (full)
            begin
                status_next = skl_pkg::ST_FULL;
            end
            else
            begin
                status_next   = skl_pkg::ST_OK;
                position_next = skl_pkg::FIELD_W'(ins_pos);
                count_next    = count_reg + CW'(1);
            end
        end
        else if (is_del && hit)
        begin
            status_next   = skl_pkg::ST_OK;
            position_next = skl_pkg::FIELD_W'(eq_pos);
            count_next    = count_reg - CW'(1);
        end
        else if (is_srch && hit)
        begin
            status_next   = skl_pkg::ST_OK;
            position_next = skl_pkg::FIELD_W'(eq_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !pend_reg)
        begin
            cmd_reg <= command;
            key_reg <= key;
        end
        if (pend_reg)
        begin
            status_reg      <= status_next;
            position_reg    <= position_next;
            entry_count_reg <= skl_pkg::FIELD_W'(count_next);
        end
    end

    assign busy        = pend_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;

`include "sorted_key_list_unit_assert.svh"

    `SKL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY))
    `SKL_ASSERT_NEXT(a_exec_result, pend_reg, done_reg && !pend_reg)
    `SKL_ASSERT_NOW(a_fail_pos, done_reg && (status_reg != skl_pkg::ST_OK), position_reg == '0)
    `SKL_ASSERT_NEXT(a_ins_count, is_ins && !full, count_reg == $past(count_reg) + CW'(1))

endmodule
